FILE: rtl/integer_matrix_multiply_assert.svh
// Assertion macros used by the matrix multiply top level.
// Depends on nothing; the including module supplies clock and reset.
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, ignored during reset
`define IMM_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("imm check failed");

// Next-cycle implication, ignored during reset
`define IMM_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("imm check failed");

`endif

FILE: rtl/imm_pkg.sv
// Types, constants and helpers for the integer matrix multiply block.
// No dependencies; used by imm_cell and integer_matrix_multiply.
package imm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int CNT_W      = IDX_W + 1;

   // input function codes
   localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [1:0] CSR_DIM       = 2'd1;
   localparam logic [1:0] CSR_FIRST_ROW = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] product;
      logic [8:0]         out_row;
      logic [2:0]         out_col;
      logic               last;
   } rsp_type;

   // operand travelling along the cell chain
   typedef struct packed {
      logic                  vld;
      logic                  first;
      logic [IDX_W-1:0]      k;
      logic [DATA_WIDTH-1:0] a;
   } link_type;

   // write of one stored element of the second matrix into a cell
   typedef struct packed {
      logic                  we;
      logic [IDX_W-1:0]      col;
      logic [DATA_WIDTH-1:0] value;
   } bload_type;

   // saturate a 4-bit size register to MAX_DIM
   function automatic logic [3:0] clamp_dim(input logic [3:0] v);
      logic [3:0] r;
      r = (32'(v) > MAX_DIM) ? 4'(MAX_DIM) : v;
      return r;
   endfunction

endpackage

FILE: rtl/imm_cell.sv
// One multiply-accumulate cell of the chain: holds one stored row of the
// second matrix and accumulates one output column. Depends on imm_pkg.
module imm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  imm_pkg::bload_type            bload,
   input  imm_pkg::link_type             link_in,
   output imm_pkg::link_type             link_out,
   output logic [imm_pkg::DATA_WIDTH-1:0] acc
);
   import imm_pkg::*;

   logic [DATA_WIDTH-1:0]   b_ff [MAX_DIM];
   link_type                link_ff;
   logic [DATA_WIDTH-1:0]   prod_ff;
   logic                    pvld_ff;
   logic                    pfirst_ff;
   logic [DATA_WIDTH-1:0]   acc_ff;
   logic [2*DATA_WIDTH-1:0] mult_in;

   // local element store, written by load transfers
   always_ff @(posedge clock) begin
      if (bload.we) begin
         b_ff[bload.col] <= bload.value;
      end
   end

   // forward operand to the neighbour
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.vld <= 1'b0;
      end else begin
         link_ff.vld <= link_in.vld;
      end
      link_ff.first <= link_in.first;
      link_ff.k     <= link_in.k;
      link_ff.a     <= link_in.a;
   end

   // multiply stage, wraps to data width
   assign mult_in = link_in.a * b_ff[link_in.k];

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= link_in.vld;
      end
      pfirst_ff <= link_in.first;
      prod_ff   <= mult_in[DATA_WIDTH-1:0];
   end

   // accumulate, restarting on the first term of a dot product
   always_ff @(posedge clock) begin
      if (pvld_ff) begin
         acc_ff <= pfirst_ff ? prod_ff : acc_ff + prod_ff;
      end
   end

   assign link_out = link_ff;
   assign acc      = acc_ff;

endmodule

FILE: rtl/integer_matrix_multiply.sv
// Top level of the integer matrix multiply block: first matrix store,
// sequencer, cell chain and result register. Depends on imm_pkg, imm_cell.
//
//   channel | ports                         | direction
//   req     | req_valid/req_ready/req_data  | in, load or compute items
//   rsp     | rsp_valid/rsp_ready/rsp_data  | out, one result per transfer
//   csr     | csr_we/csr_index/csr_wdata    | in, register writes
//
// Per row, a compute steps through feed, drain (its length set by the
// chain length) and emit states, the last stalling on rsp_ready. Items
// are taken one at a time.
// Reset is synchronous and clears control state; matrix contents are
// undefined until written.
module integer_matrix_multiply (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  imm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output imm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import imm_pkg::*;

   `include "integer_matrix_multiply_assert.svh"

   localparam int DRAIN_CYCLES = MAX_DIM + 4;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FEED  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [3:0]            row_count_ff, dim_ff;
   logic [7:0]            first_row_ff;
   logic [3:0]            rows_ff, rows_in, cols_ff, cols_in;
   logic [IDX_W-1:0]      row_ff, row_in, k_ff, k_in, col_ff, col_in;
   logic [DRAIN_W-1:0]    wait_ff, wait_in;
   logic [DATA_WIDTH-1:0] mem_a [MAX_DIM*MAX_DIM];
   logic [DATA_WIDTH-1:0] a_rd_ff;
   logic                  feed_vld_ff;
   logic                  feed_first_ff;
   logic [IDX_W-1:0]      feed_k_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;
   logic                  req_xfer, load_rsp, k_last, col_last, row_last;
   link_type              link [MAX_DIM+1];
   logic [DATA_WIDTH-1:0] acc_arr [MAX_DIM];
   bload_type             bload [MAX_DIM];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign k_last    = ({1'b0, k_ff} == cols_ff - 4'd1);
   assign col_last  = ({1'b0, col_ff} == cols_ff - 4'd1);
   assign row_last  = ({1'b0, row_ff} == rows_ff - 4'd1);
   assign load_rsp  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 4'd1;
         dim_ff       <= 4'd1;
         first_row_ff <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_wdata[3:0];
            CSR_DIM:       dim_ff       <= csr_wdata[3:0];
            CSR_FIRST_ROW: first_row_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // first matrix store: load writes, feed reads with registered data
   always_ff @(posedge clock) begin
      if (req_xfer && req_data.func == FUNC_LOAD_A) begin
         mem_a[{req_data.row, req_data.col}] <= req_data.value;
      end
      a_rd_ff <= mem_a[{row_ff, k_ff}];
   end

   // operand feed into the head of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_vld_ff <= 1'b0;
      end else begin
         feed_vld_ff <= (state_ff == ST_FEED);
      end
      feed_first_ff <= (k_ff == '0);
      feed_k_ff     <= k_ff;
   end

   assign link[0].vld   = feed_vld_ff;
   assign link[0].first = feed_first_ff;
   assign link[0].k     = feed_k_ff;
   assign link[0].a     = a_rd_ff;

   // cell chain, one cell per output column
   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      assign bload[j].we    = req_xfer && (req_data.func == FUNC_LOAD_B)
                              && (req_data.row == IDX_W'(j));
      assign bload[j].col   = req_data.col;
      assign bload[j].value = req_data.value;

      imm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bload    (bload[j]),
         .link_in  (link[j]),
         .link_out (link[j+1]),
         .acc      (acc_arr[j])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      col_in   = col_ff;
      wait_in  = wait_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_data.func == FUNC_COMPUTE) begin
               rows_in = clamp_dim(row_count_ff);
               cols_in = clamp_dim(dim_ff);
               row_in  = '0;
               k_in    = '0;
               if (rows_in != 4'd0 && cols_in != 4'd0) begin
                  state_in = ST_FEED;
               end
            end
         end
         ST_FEED: begin
            if (k_last) begin
               wait_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (wait_ff == DRAIN_W'(DRAIN_CYCLES - 1)) begin
               col_in   = '0;
               state_in = ST_EMIT;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               if (col_last) begin
                  k_in = '0;
                  if (row_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     row_in   = row_ff + 1'b1;
                     state_in = ST_FEED;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         k_ff     <= '0;
         col_ff   <= '0;
         wait_ff  <= '0;
         rows_ff  <= 4'd1;
         cols_ff  <= 4'd1;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         k_ff     <= k_in;
         col_ff   <= col_in;
         wait_ff  <= wait_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_ff.product <= acc_arr[col_ff];
         rsp_ff.out_row <= {1'b0, first_row_ff} + {6'd0, row_ff};
         rsp_ff.out_col <= col_ff;
         rsp_ff.last    <= row_last && col_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IMM_ASSERT_IMP(a_feed_k_range, state_ff == ST_FEED, {1'b0, k_ff} < cols_ff)
   `IMM_ASSERT_IMP(a_emit_col_range, state_ff == ST_EMIT, {1'b0, col_ff} < cols_ff)
   `IMM_ASSERT_NXT(a_last_ends_run, load_rsp && row_last && col_last, state_ff == ST_IDLE)
   `IMM_ASSERT_NXT(a_compute_starts, req_xfer && req_data.func == FUNC_COMPUTE
      && clamp_dim(row_count_ff) != 4'd0 && clamp_dim(dim_ff) != 4'd0,
      state_ff == ST_FEED)

endmodule
